@@ rtl/igp_pkg.sv @@
package igp_pkg;

   // Default grid side limit
   localparam int GRID_MAX_DEF = 64;

   // Field and datapath widths
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 32;
   localparam int CFG_W      = 32;
   localparam int SIZE_W     = 7;
   localparam int STEPS_W    = 16;
   localparam int INDEX_W    = 12;
   localparam int VALUE_W    = 32;
   localparam int L20_W      = 28;
   localparam int XY_W       = 20;
   localparam int ROOT_W     = 32;
   localparam int SUM_W      = 48;
   localparam int NN_W       = 14;
   localparam int DIV_W      = 64;
   localparam int DIV_CNT_W  = 6;
   localparam int SQRT_CNT_W = 5;

   // Fixed-point constants
   localparam logic [31:0] ONE_Q16  = 32'h0001_0000;
   localparam logic [31:0] ONE_Q30  = 32'h4000_0000;
   localparam logic [31:0] TWO_Q30  = 32'h8000_0000;
   localparam logic [31:0] SAT32    = 32'hFFFF_FFFF;
   localparam logic [31:0] RD_RESET = 32'd21474836;
   localparam logic [31:0] LD_RESET = 32'd16777216;

   typedef enum logic {
      REQ_START = 1'b0,
      REQ_READ  = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      REPLY_DONE   = 2'd0,
      REPLY_CELL   = 2'd1,
      REPLY_REJECT = 2'd2
   } reply_kind_type;

   typedef enum logic {
      CSR_APERTURE = 1'b0,
      CSR_DISTANCE = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      MS_HOLD, MS_COORD_RD, MS_XX, MS_YY, MS_LL, MS_IK, MS_NT, MS_II
   } mul_sel_type;

   typedef enum logic [1:0] {
      DS_NONE, DS_PROD_N, DS_RATIO, DS_SUM
   } div_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD, ACC_CLR, ACC_LOAD, ACC_ADD
   } acc_op_type;

   typedef enum logic [1:0] {
      IW_ONE, IW_QUOT, IW_SQR
   } iw_src_type;

   typedef enum logic [4:0] {
      S_IDLE, S_READ, S_INIT,
      S_KX_MUL, S_KX_DIV, S_KX_WAIT,
      S_KY_MUL, S_KY_DIV, S_KY_WAIT,
      S_KS_XX, S_KS_YY, S_KS_LL, S_KS_SUM, S_KS_SQRT, S_KS_SQW,
      S_KR_DIV, S_KR_WAIT,
      S_ST_BEGIN, S_PR_RD, S_PR_MUL, S_PR_ACC, S_PR_WR,
      S_RN_RD, S_RN_MUL, S_RN_DIV, S_RN_WAIT, S_RN_END,
      S_SQ_RD, S_SQ_MUL, S_SQ_WR, S_DONE
   } ctl_state_type;

   typedef struct packed {
      mul_sel_type mul_sel;
      div_sel_type div_sel;
      acc_op_type  acc_op;
      logic        sqrt_start;
      logic        x_load;
      logic        y_load;
      logic        k_we;
      logic        n_we;
      logic        sum_clr;
      logic        i_we;
      iw_src_type  i_src;
      logic        chg_clr;
      logic        chg_upd;
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;
      logic sqrt_done;
      logic d_zero;
      logic sum_zero;
      logic changed;
   } dp_status_type;

endpackage

@@ rtl/igp_divider.sv @@
// Restoring divider, one quotient bit per cycle.
module igp_divider (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [igp_pkg::DIV_W-1:0] dividend,
   input  logic [igp_pkg::DIV_W-1:0] divisor,
   output logic                     done,
   output logic [igp_pkg::DIV_W-1:0] quotient
);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [igp_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [igp_pkg::DIV_W-1:0]       rem_ff, rem_in;
   logic [igp_pkg::DIV_W-1:0]       quo_ff, quo_in;
   logic [igp_pkg::DIV_W-1:0]       dvs_ff, dvs_in;
   logic [igp_pkg::DIV_W:0]         rem_sh;
   logic                            fits;

   // One shift-subtract step per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      rem_sh  = {rem_ff, quo_ff[igp_pkg::DIV_W-1]};
      fits    = rem_sh >= {1'b0, dvs_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? igp_pkg::DIV_W'(rem_sh - {1'b0, dvs_ff})
                       : igp_pkg::DIV_W'(rem_sh);
         quo_in = {quo_ff[igp_pkg::DIV_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == '1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ rtl/igp_sqrt.sv @@
// Integer square root, one result bit per cycle.
module igp_sqrt (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [63:0]               value,
   output logic                      done,
   output logic [igp_pkg::ROOT_W-1:0] root
);

   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [igp_pkg::SQRT_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [63:0]                      val_ff, val_in;
   logic [63:0]                      res_ff, res_in;
   logic [63:0]                      bit_ff, bit_in;
   logic [63:0]                      trial;

   // Digit-by-digit root, two radicand bits per step
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      val_in  = val_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      trial   = res_ff + bit_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         val_in  = value;
         res_in  = '0;
         bit_in  = 64'h4000_0000_0000_0000;
      end else if (busy_ff) begin
         if (val_ff >= trial) begin
            val_in = val_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == '1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      val_ff <= val_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = res_ff[igp_pkg::ROOT_W-1:0];

endmodule

@@ rtl/igp_datapath.sv @@
// Grid memories, shared multiplier, accumulators, divider and root unit.
module igp_datapath #(
   parameter int GRID_MAX = igp_pkg::GRID_MAX_DEF,
   localparam int DEPTH   = GRID_MAX * GRID_MAX,
   localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int IW      = (GRID_MAX > 1) ? $clog2(GRID_MAX) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  igp_pkg::dp_cmd_type         cmd,
   input  logic [AW-1:0]               addr_i,
   input  logic [AW-1:0]               addr_k,
   input  logic [AW-1:0]               addr_n,
   input  logic [IW-1:0]               coord,
   input  logic [igp_pkg::SIZE_W-1:0]  size,
   input  logic [igp_pkg::CFG_W-1:0]   aperture,
   input  logic [igp_pkg::L20_W-1:0]   l20,
   output igp_pkg::dp_status_type      status,
   output logic [igp_pkg::VALUE_W-1:0] cell_data
);

   logic [31:0]                imem [DEPTH];
   logic [31:0]                kmem [DEPTH];
   logic [31:0]                nmem [DEPTH];
   logic [31:0]                rdata_i_ff, rdata_k_ff, rdata_n_ff;

   logic [63:0]                prod_ff, prod_in;
   logic [63:0]                acc_ff, acc_in;
   logic [igp_pkg::XY_W-1:0]   x_ff, x_in, y_ff, y_in;
   logic [igp_pkg::SUM_W-1:0]  sum_ff, sum_in;
   logic                       chg_ff, chg_in;

   logic [31:0]                ma, mb;
   logic [31:0]                target;
   logic [31:0]                i_wdata, k_wdata, n_wdata;
   logic                       div_start, div_done, sqrt_done;
   logic [igp_pkg::DIV_W-1:0]  dividend, divisor, quot;
   logic [igp_pkg::ROOT_W-1:0] root;

   assign target  = 32'(32'(size) * 32'(size)) << 16;
   assign n_wdata = acc_ff[61:30];
   assign k_wdata = (root == '0) ? igp_pkg::TWO_Q30 : igp_pkg::ONE_Q30 + quot[31:0];

   // Intensity write source
   always_comb begin
      case (cmd.i_src)
         igp_pkg::IW_ONE:  i_wdata = igp_pkg::ONE_Q16;
         igp_pkg::IW_QUOT: i_wdata = quot[31:0];
         igp_pkg::IW_SQR:  i_wdata = (prod_ff[63:48] != '0) ? igp_pkg::SAT32 : prod_ff[47:16];
         default:          i_wdata = igp_pkg::ONE_Q16;
      endcase
   end

   // Grid memories with registered read
   always_ff @(posedge clock) begin
      if (cmd.i_we) begin
         imem[addr_i] <= i_wdata;
      end
      rdata_i_ff <= imem[addr_i];
   end

   always_ff @(posedge clock) begin
      if (cmd.k_we) begin
         kmem[addr_k] <= k_wdata;
      end
      rdata_k_ff <= kmem[addr_k];
   end

   always_ff @(posedge clock) begin
      if (cmd.n_we) begin
         nmem[addr_n] <= n_wdata;
      end
      rdata_n_ff <= nmem[addr_n];
   end

   // Shared multiplier operands
   always_comb begin
      case (cmd.mul_sel)
         igp_pkg::MS_COORD_RD: begin ma = 32'(coord);   mb = aperture;   end
         igp_pkg::MS_XX:       begin ma = 32'(x_ff);    mb = 32'(x_ff);  end
         igp_pkg::MS_YY:       begin ma = 32'(y_ff);    mb = 32'(y_ff);  end
         igp_pkg::MS_LL:       begin ma = 32'(l20);     mb = 32'(l20);   end
         igp_pkg::MS_IK:       begin ma = rdata_i_ff;   mb = rdata_k_ff; end
         igp_pkg::MS_NT:       begin ma = rdata_n_ff;   mb = target;     end
         igp_pkg::MS_II:       begin ma = rdata_i_ff;   mb = rdata_i_ff; end
         default:              begin ma = '0;           mb = '0;         end
      endcase
   end

   // Divider operand selection
   always_comb begin
      div_start = 1'b1;
      case (cmd.div_sel)
         igp_pkg::DS_PROD_N: begin
            dividend = prod_ff;
            divisor  = igp_pkg::DIV_W'(size);
         end
         igp_pkg::DS_RATIO: begin
            dividend = igp_pkg::DIV_W'(l20) << 30;
            divisor  = igp_pkg::DIV_W'(root);
         end
         igp_pkg::DS_SUM: begin
            dividend = prod_ff;
            divisor  = igp_pkg::DIV_W'(sum_ff);
         end
         default: begin
            div_start = 1'b0;
            dividend  = prod_ff;
            divisor   = igp_pkg::DIV_W'(size);
         end
      endcase
   end

   // Product, accumulator, coordinates, grid sum and change flag
   always_comb begin
      prod_in = (cmd.mul_sel == igp_pkg::MS_HOLD) ? prod_ff : 64'(ma) * 64'(mb);
      case (cmd.acc_op)
         igp_pkg::ACC_CLR:  acc_in = '0;
         igp_pkg::ACC_LOAD: acc_in = prod_ff;
         igp_pkg::ACC_ADD:  acc_in = acc_ff + prod_ff;
         default:           acc_in = acc_ff;
      endcase
      x_in   = cmd.x_load ? quot[31:12] : x_ff;
      y_in   = cmd.y_load ? quot[31:12] : y_ff;
      sum_in = sum_ff;
      if (cmd.sum_clr) begin
         sum_in = '0;
      end else if (cmd.n_we) begin
         sum_in = sum_ff + igp_pkg::SUM_W'(n_wdata);
      end
      chg_in = chg_ff;
      if (cmd.chg_clr) begin
         chg_in = 1'b0;
      end else if (cmd.chg_upd && (i_wdata != rdata_i_ff)) begin
         chg_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         chg_ff <= 1'b0;
      end else begin
         sum_ff <= sum_in;
         chg_ff <= chg_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
   end

   igp_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quot)
   );

   igp_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (cmd.sqrt_start),
      .value (acc_ff),
      .done  (sqrt_done),
      .root  (root)
   );

   assign status.div_done  = div_done;
   assign status.sqrt_done = sqrt_done;
   assign status.d_zero    = (root == '0);
   assign status.sum_zero  = (sum_ff == '0);
   assign status.changed   = chg_ff;
   assign cell_data        = rdata_i_ff;

endmodule

@@ rtl/igp_controller.sv @@
// Sequencer: request decode, loop counters and datapath commands.
module igp_controller #(
   parameter int GRID_MAX = igp_pkg::GRID_MAX_DEF,
   localparam int DEPTH   = GRID_MAX * GRID_MAX,
   localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int IW      = (GRID_MAX > 1) ? $clog2(GRID_MAX) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  igp_pkg::req_kind_type       req_kind,
   input  logic [igp_pkg::SIZE_W-1:0]  req_size,
   input  logic [igp_pkg::STEPS_W-1:0] req_steps,
   input  logic [igp_pkg::INDEX_W-1:0] req_index,
   input  logic                        rsp_free,
   output logic                        req_ready,
   output logic                        rsp_load,
   output igp_pkg::reply_kind_type     rsp_kind,
   input  igp_pkg::dp_status_type      status,
   output igp_pkg::dp_cmd_type         cmd,
   output logic [AW-1:0]               addr_i,
   output logic [AW-1:0]               addr_k,
   output logic [AW-1:0]               addr_n,
   output logic [IW-1:0]               coord,
   output logic [igp_pkg::SIZE_W-1:0]  size
);

   igp_pkg::ctl_state_type        state_ff, state_in;
   logic [igp_pkg::SIZE_W-1:0]    size_ff, size_in;
   logic [igp_pkg::STEPS_W-1:0]   steps_ff, steps_in;
   logic [igp_pkg::STEPS_W-1:0]   step_cnt_ff, step_cnt_in;
   logic                          ready_ff, ready_in;
   logic [IW-1:0]                 ca_ff, ca_in, cb_ff, cb_in;
   logic [IW-1:0]                 ci_ff, ci_in, cj_ff, cj_in;
   logic [IW-1:0]                 ck_ff, ck_in, cl_ff, cl_in;
   logic [AW-1:0]                 cc_ff, cc_in;

   logic [igp_pkg::SIZE_W-1:0]    size_m1;
   logic [igp_pkg::NN_W-1:0]      nn;
   logic                          last_a, last_b, last_i, last_j, last_k, last_l, last_c;
   logic [IW-1:0]                 di, dj;
   logic [AW-1:0]                 pos_ab, pos_ij, pos_src, pos_ker;
   logic                          kern_adv, rn_adv;

   // Loop bounds and addresses
   assign size_m1 = size_ff - 1'b1;
   assign nn      = igp_pkg::NN_W'(32'(size_ff) * 32'(size_ff));
   assign last_a  = (igp_pkg::SIZE_W'(ca_ff) == size_m1);
   assign last_b  = (igp_pkg::SIZE_W'(cb_ff) == size_m1);
   assign last_i  = (igp_pkg::SIZE_W'(ci_ff) == size_m1);
   assign last_j  = (igp_pkg::SIZE_W'(cj_ff) == size_m1);
   assign last_k  = (igp_pkg::SIZE_W'(ck_ff) == size_m1);
   assign last_l  = (igp_pkg::SIZE_W'(cl_ff) == size_m1);
   assign last_c  = (32'(cc_ff) == 32'(nn) - 32'd1);
   assign di      = (ck_ff > ci_ff) ? ck_ff - ci_ff : ci_ff - ck_ff;
   assign dj      = (cl_ff > cj_ff) ? cl_ff - cj_ff : cj_ff - cl_ff;
   assign pos_ab  = AW'(32'(ca_ff) * 32'(size_ff) + 32'(cb_ff));
   assign pos_ij  = AW'(32'(ci_ff) * 32'(size_ff) + 32'(cj_ff));
   assign pos_src = AW'(32'(ck_ff) * 32'(size_ff) + 32'(cl_ff));
   assign pos_ker = AW'(32'(di) * 32'(size_ff) + 32'(dj));
   assign size    = size_ff;

   // Next state and datapath commands
   always_comb begin
      state_in    = state_ff;
      size_in     = size_ff;
      steps_in    = steps_ff;
      step_cnt_in = step_cnt_ff;
      ready_in    = ready_ff;
      ca_in       = ca_ff;
      cb_in       = cb_ff;
      ci_in       = ci_ff;
      cj_in       = cj_ff;
      ck_in       = ck_ff;
      cl_in       = cl_ff;
      cc_in       = cc_ff;
      cmd         = '0;
      req_ready   = 1'b0;
      rsp_load    = 1'b0;
      rsp_kind    = igp_pkg::REPLY_REJECT;
      addr_i      = cc_ff;
      addr_k      = pos_ab;
      addr_n      = cc_ff;
      coord       = cb_ff;
      kern_adv    = 1'b0;
      rn_adv      = 1'b0;

      case (state_ff)
         igp_pkg::S_IDLE: begin
            req_ready = rsp_free;
            addr_i    = AW'(req_index);
            if (req_valid && rsp_free) begin
               if (req_kind == igp_pkg::REQ_START) begin
                  if ((req_size == '0) || (32'(req_size) > 32'(GRID_MAX))) begin
                     rsp_load = 1'b1;
                  end else begin
                     size_in  = req_size;
                     steps_in = req_steps;
                     cc_in    = '0;
                     state_in = igp_pkg::S_INIT;
                  end
               end else if (ready_ff && (32'(req_index) < 32'(nn))) begin
                  state_in = igp_pkg::S_READ;
               end else begin
                  rsp_load = 1'b1;
               end
            end
         end
         igp_pkg::S_READ: begin
            rsp_load = 1'b1;
            rsp_kind = igp_pkg::REPLY_CELL;
            state_in = igp_pkg::S_IDLE;
         end
         igp_pkg::S_INIT: begin
            cmd.i_we  = 1'b1;
            cmd.i_src = igp_pkg::IW_ONE;
            if (last_c) begin
               ca_in    = '0;
               cb_in    = '0;
               state_in = igp_pkg::S_KX_MUL;
            end else begin
               cc_in = cc_ff + 1'b1;
            end
         end
         // Kernel: x from the row offset
         igp_pkg::S_KX_MUL: begin
            coord       = ca_ff;
            cmd.mul_sel = igp_pkg::MS_COORD_RD;
            state_in    = igp_pkg::S_KX_DIV;
         end
         igp_pkg::S_KX_DIV: begin
            cmd.div_sel = igp_pkg::DS_PROD_N;
            state_in    = igp_pkg::S_KX_WAIT;
         end
         igp_pkg::S_KX_WAIT: begin
            if (status.div_done) begin
               cmd.x_load = 1'b1;
               state_in   = igp_pkg::S_KY_MUL;
            end
         end
         // Kernel: y from the column offset
         igp_pkg::S_KY_MUL: begin
            coord       = cb_ff;
            cmd.mul_sel = igp_pkg::MS_COORD_RD;
            state_in    = igp_pkg::S_KY_DIV;
         end
         igp_pkg::S_KY_DIV: begin
            cmd.div_sel = igp_pkg::DS_PROD_N;
            state_in    = igp_pkg::S_KY_WAIT;
         end
         igp_pkg::S_KY_WAIT: begin
            if (status.div_done) begin
               cmd.y_load = 1'b1;
               state_in   = igp_pkg::S_KS_XX;
            end
         end
         // Kernel: squared distance and its root
         igp_pkg::S_KS_XX: begin
            cmd.mul_sel = igp_pkg::MS_XX;
            state_in    = igp_pkg::S_KS_YY;
         end
         igp_pkg::S_KS_YY: begin
            cmd.acc_op  = igp_pkg::ACC_LOAD;
            cmd.mul_sel = igp_pkg::MS_YY;
            state_in    = igp_pkg::S_KS_LL;
         end
         igp_pkg::S_KS_LL: begin
            cmd.acc_op  = igp_pkg::ACC_ADD;
            cmd.mul_sel = igp_pkg::MS_LL;
            state_in    = igp_pkg::S_KS_SUM;
         end
         igp_pkg::S_KS_SUM: begin
            cmd.acc_op = igp_pkg::ACC_ADD;
            state_in   = igp_pkg::S_KS_SQRT;
         end
         igp_pkg::S_KS_SQRT: begin
            cmd.sqrt_start = 1'b1;
            state_in       = igp_pkg::S_KS_SQW;
         end
         igp_pkg::S_KS_SQW: begin
            if (status.sqrt_done) begin
               state_in = igp_pkg::S_KR_DIV;
            end
         end
         // Kernel: one plus the ratio ld/d, or two when the distance is zero
         igp_pkg::S_KR_DIV: begin
            if (status.d_zero) begin
               cmd.k_we = 1'b1;
               kern_adv = 1'b1;
            end else begin
               cmd.div_sel = igp_pkg::DS_RATIO;
               state_in    = igp_pkg::S_KR_WAIT;
            end
         end
         igp_pkg::S_KR_WAIT: begin
            if (status.div_done) begin
               cmd.k_we = 1'b1;
               kern_adv = 1'b1;
            end
         end
         // Propagation step
         igp_pkg::S_ST_BEGIN: begin
            cmd.acc_op  = igp_pkg::ACC_CLR;
            cmd.sum_clr = 1'b1;
            cmd.chg_clr = 1'b1;
            ci_in       = '0;
            cj_in       = '0;
            ck_in       = '0;
            cl_in       = '0;
            state_in    = igp_pkg::S_PR_RD;
         end
         igp_pkg::S_PR_RD: begin
            addr_i   = pos_src;
            addr_k   = pos_ker;
            state_in = igp_pkg::S_PR_MUL;
         end
         igp_pkg::S_PR_MUL: begin
            addr_i      = pos_src;
            addr_k      = pos_ker;
            cmd.mul_sel = igp_pkg::MS_IK;
            state_in    = igp_pkg::S_PR_ACC;
         end
         igp_pkg::S_PR_ACC: begin
            addr_i     = pos_src;
            addr_k     = pos_ker;
            cmd.acc_op = igp_pkg::ACC_ADD;
            state_in   = igp_pkg::S_PR_RD;
            if (last_l) begin
               cl_in = '0;
               if (last_k) begin
                  ck_in    = '0;
                  state_in = igp_pkg::S_PR_WR;
               end else begin
                  ck_in = ck_ff + 1'b1;
               end
            end else begin
               cl_in = cl_ff + 1'b1;
            end
         end
         igp_pkg::S_PR_WR: begin
            addr_n     = pos_ij;
            cmd.n_we   = 1'b1;
            cmd.acc_op = igp_pkg::ACC_CLR;
            state_in   = igp_pkg::S_PR_RD;
            if (last_j) begin
               cj_in = '0;
               if (last_i) begin
                  ci_in    = '0;
                  cc_in    = '0;
                  state_in = igp_pkg::S_RN_RD;
               end else begin
                  ci_in = ci_ff + 1'b1;
               end
            end else begin
               cj_in = cj_ff + 1'b1;
            end
         end
         // Renormalization to a mean of one
         igp_pkg::S_RN_RD: begin
            state_in = igp_pkg::S_RN_MUL;
         end
         igp_pkg::S_RN_MUL: begin
            cmd.mul_sel = igp_pkg::MS_NT;
            state_in    = igp_pkg::S_RN_DIV;
         end
         igp_pkg::S_RN_DIV: begin
            if (status.sum_zero) begin
               cmd.i_we    = 1'b1;
               cmd.i_src   = igp_pkg::IW_ONE;
               cmd.chg_upd = 1'b1;
               rn_adv      = 1'b1;
            end else begin
               cmd.div_sel = igp_pkg::DS_SUM;
               state_in    = igp_pkg::S_RN_WAIT;
            end
         end
         igp_pkg::S_RN_WAIT: begin
            if (status.div_done) begin
               cmd.i_we    = 1'b1;
               cmd.i_src   = igp_pkg::IW_QUOT;
               cmd.chg_upd = 1'b1;
               rn_adv      = 1'b1;
            end
         end
         igp_pkg::S_RN_END: begin
            if (!status.changed || (step_cnt_ff + 1'b1 == steps_ff)) begin
               cc_in    = '0;
               state_in = igp_pkg::S_SQ_RD;
            end else begin
               step_cnt_in = step_cnt_ff + 1'b1;
               state_in    = igp_pkg::S_ST_BEGIN;
            end
         end
         // Final squaring
         igp_pkg::S_SQ_RD: begin
            state_in = igp_pkg::S_SQ_MUL;
         end
         igp_pkg::S_SQ_MUL: begin
            cmd.mul_sel = igp_pkg::MS_II;
            state_in    = igp_pkg::S_SQ_WR;
         end
         igp_pkg::S_SQ_WR: begin
            cmd.i_we  = 1'b1;
            cmd.i_src = igp_pkg::IW_SQR;
            if (last_c) begin
               state_in = igp_pkg::S_DONE;
            end else begin
               cc_in    = cc_ff + 1'b1;
               state_in = igp_pkg::S_SQ_RD;
            end
         end
         igp_pkg::S_DONE: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               rsp_kind = igp_pkg::REPLY_DONE;
               ready_in = 1'b1;
               state_in = igp_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = igp_pkg::S_IDLE;
         end
      endcase

      // Step to the next kernel entry
      if (kern_adv) begin
         if (last_b) begin
            cb_in = '0;
            if (last_a) begin
               if (steps_ff == '0) begin
                  cc_in    = '0;
                  state_in = igp_pkg::S_SQ_RD;
               end else begin
                  step_cnt_in = '0;
                  state_in    = igp_pkg::S_ST_BEGIN;
               end
            end else begin
               ca_in    = ca_ff + 1'b1;
               state_in = igp_pkg::S_KX_MUL;
            end
         end else begin
            cb_in    = cb_ff + 1'b1;
            state_in = igp_pkg::S_KY_MUL;
         end
      end

      // Step to the next cell of the renormalization
      if (rn_adv) begin
         if (last_c) begin
            state_in = igp_pkg::S_RN_END;
         end else begin
            cc_in    = cc_ff + 1'b1;
            state_in = igp_pkg::S_RN_RD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= igp_pkg::S_IDLE;
         size_ff     <= '0;
         steps_ff    <= '0;
         step_cnt_ff <= '0;
         ready_ff    <= 1'b0;
         ca_ff       <= '0;
         cb_ff       <= '0;
         ci_ff       <= '0;
         cj_ff       <= '0;
         ck_ff       <= '0;
         cl_ff       <= '0;
         cc_ff       <= '0;
      end else begin
         state_ff    <= state_in;
         size_ff     <= size_in;
         steps_ff    <= steps_in;
         step_cnt_ff <= step_cnt_in;
         ready_ff    <= ready_in;
         ca_ff       <= ca_in;
         cb_ff       <= cb_in;
         ci_ff       <= ci_in;
         cj_ff       <= cj_in;
         ck_ff       <= ck_in;
         cl_ff       <= cl_in;
         cc_ff       <= cc_in;
      end
   end

endmodule

@@ rtl/iterated_grid_propagation_unit.sv @@
// Channel   Direction  Contents
// req_      in         tuser: req_type; tdata: grid_size, iteration_count, cell_index
// rsp_      out        tuser: reply_kind; tdata: cell_value
// csr_      in         write enable, register index, 32-bit data
//
// A read is accepted from idle and its reply is loaded in the cycle after, so no new
// request is taken before that reply is loaded; a rejected request is answered at the
// cycle it is accepted. A start fills the grid, builds each kernel entry with a divide
// for y, a root and, unless the distance is zero, a divide for the ratio, with a divide
// for x per kernel row, then runs per step a multiply-accumulate over the grid for every
// cell and, unless the grid sum is zero, a divide per cell for renormalization, and ends
// with a final squaring pass; the one shared multiplier and the bit-serial divider set
// its length.
// Reset is synchronous; grid memories hold no reset value and need no clearing.
// A full reply register blocks new requests until the reply is taken.
module iterated_grid_propagation_unit #(
   parameter int GRID_MAX = igp_pkg::GRID_MAX_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [igp_pkg::REQ_DATA_W-1:0] req_tdata,  // grid_size, iteration_count, cell_index
   input  logic [0:0]                     req_tuser,  // req_type
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [igp_pkg::RSP_DATA_W-1:0] rsp_tdata,  // cell_value
   output logic [1:0]                     rsp_tuser,  // reply_kind
   input  logic                           csr_we,
   input  logic [0:0]                     csr_index,
   input  logic [igp_pkg::CFG_W-1:0]      csr_wdata
);

   localparam int DEPTH = GRID_MAX * GRID_MAX;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int IW    = (GRID_MAX > 1) ? $clog2(GRID_MAX) : 1;

   logic [igp_pkg::CFG_W-1:0]   rd_ff, rd_in, ld_ff, ld_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   igp_pkg::reply_kind_type     rsp_kind_ff, rsp_kind_in;
   logic [igp_pkg::VALUE_W-1:0] rsp_value_ff, rsp_value_in;

   logic                        rsp_free, rsp_load;
   igp_pkg::reply_kind_type     rsp_kind;
   igp_pkg::dp_cmd_type         cmd;
   igp_pkg::dp_status_type      status;
   logic [AW-1:0]               addr_i, addr_k, addr_n;
   logic [IW-1:0]               coord;
   logic [igp_pkg::SIZE_W-1:0]  size;
   logic [igp_pkg::VALUE_W-1:0] cell_data;

   // Configuration registers
   always_comb begin
      rd_in = rd_ff;
      ld_in = ld_ff;
      if (csr_we) begin
         case (igp_pkg::csr_index_type'(csr_index))
            igp_pkg::CSR_APERTURE: rd_in = csr_wdata;
            igp_pkg::CSR_DISTANCE: ld_in = csr_wdata;
            default:               rd_in = rd_ff;
         endcase
      end
   end

   // Reply register
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_value_in = rsp_value_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = rsp_kind;
         rsp_value_in = (rsp_kind == igp_pkg::REPLY_CELL) ? cell_data : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff        <= igp_pkg::RD_RESET;
         ld_ff        <= igp_pkg::LD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_ff        <= rd_in;
         ld_ff        <= ld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff  <= rsp_kind_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_kind_ff;

   igp_controller #(
      .GRID_MAX (GRID_MAX)
   ) u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_kind  (igp_pkg::req_kind_type'(req_tuser[0])),
      .req_size  (req_tdata[6:0]),
      .req_steps (req_tdata[22:7]),
      .req_index (req_tdata[34:23]),
      .rsp_free  (rsp_free),
      .req_ready (req_tready),
      .rsp_load  (rsp_load),
      .rsp_kind  (rsp_kind),
      .status    (status),
      .cmd       (cmd),
      .addr_i    (addr_i),
      .addr_k    (addr_k),
      .addr_n    (addr_n),
      .coord     (coord),
      .size      (size)
   );

   igp_datapath #(
      .GRID_MAX (GRID_MAX)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .addr_i    (addr_i),
      .addr_k    (addr_k),
      .addr_n    (addr_n),
      .coord     (coord),
      .size      (size),
      .aperture  (rd_ff),
      .l20       (ld_ff[31:4]),
      .status    (status),
      .cell_data (cell_data)
   );

endmodule

@@ tb/tb_iterated_grid_propagation_unit.sv @@
`timescale 1ns / 1ps

module tb_iterated_grid_propagation_unit;
   import igp_pkg::*;

   localparam int CELLS      = GRID_MAX_DEF * GRID_MAX_DEF;
   localparam int IDLE_LIMIT = 3000000;

   typedef struct {
      reply_kind_type kind;
      logic [31:0]    value;
   } cell_reply_t;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [0:0]            req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  csr_we;
   logic [0:0]            csr_index;
   logic [CFG_W-1:0]      csr_wdata;

   iterated_grid_propagation_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Shadow state of the block.
   logic [31:0]     cur_grid [CELLS];
   logic [31:0]     new_grid [CELLS];
   logic [31:0]     kern_tab [CELLS];
   int unsigned     live_size;
   longint unsigned live_sum;
   bit              grid_valid;
   logic [31:0]     rd_reg;
   logic [31:0]     ld_reg;

   cell_reply_t pending_replies[$];
   int          error_count;
   int          burst_left;
   int unsigned idle_cycles;
   int unsigned stall_phase;
   int          stall_mode;

   // Clock generation.
   always #10 clock = ~clock;

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned res, probe;
      res   = 0;
      probe = 64'h4000_0000_0000_0000;
      while (probe > v) probe >>= 2;
      while (probe != 0) begin
         if (v >= res + probe) begin
            v   = v - (res + probe);
            res = (res >> 1) + probe;
         end else begin
            res >>= 1;
         end
         probe >>= 2;
      end
      return res;
   endfunction

   // Full computation of a start: kernel, iterated propagation, final squaring.
   task automatic compute_grid(input int unsigned n, input int unsigned steps);
      longint unsigned l20, x, y, d, ratio, acc, target, q, sq;
      int unsigned     di, dj;
      bit              changed;
      for (int c = 0; c < n * n; c++) cur_grid[c] = ONE_Q16;
      l20 = ld_reg >> 4;
      for (int a = 0; a < n; a++) begin
         x = ((longint'(a) * rd_reg) / n) >> 12;
         for (int b = 0; b < n; b++) begin
            y = ((longint'(b) * rd_reg) / n) >> 12;
            d = int_sqrt(x * x + y * y + l20 * l20);
            ratio = (d != 0) ? ((l20 << 30) / d) : longint'(ONE_Q30);
            kern_tab[a * n + b] = 32'(longint'(ONE_Q30) + ratio);
         end
      end
      for (int s = 0; s < steps; s++) begin
         live_sum = 0;
         for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
               acc = 0;
               for (int i1 = 0; i1 < n; i1++) begin
                  di = (i1 > i) ? i1 - i : i - i1;
                  for (int j1 = 0; j1 < n; j1++) begin
                     dj = (j1 > j) ? j1 - j : j - j1;
                     acc += longint'(cur_grid[i1 * n + j1]) * kern_tab[di * n + dj];
                  end
               end
               new_grid[i * n + j] = 32'(acc >> 30);
               live_sum += new_grid[i * n + j];
            end
         end
         live_sum &= 48'hFFFF_FFFF_FFFF;
         target  = longint'(n) * n * ONE_Q16;
         changed = 0;
         for (int c = 0; c < n * n; c++) begin
            q = ONE_Q16;
            if (live_sum != 0) q = (longint'(new_grid[c]) * target) / live_sum;
            if (32'(q) != cur_grid[c]) changed = 1;
            cur_grid[c] = 32'(q);
         end
         if (!changed) break;
      end
      for (int c = 0; c < n * n; c++) begin
         sq = (longint'(cur_grid[c]) * cur_grid[c]) >> 16;
         cur_grid[c] = (sq > SAT32) ? SAT32 : 32'(sq);
      end
   endtask

   // Works out the reply to one accepted request and queues it.
   task automatic predict_reply(input req_kind_type k, input int unsigned n,
                                input int unsigned steps, input int unsigned idx);
      cell_reply_t r;
      r.kind  = REPLY_REJECT;
      r.value = '0;
      if (k == REQ_START) begin
         if (n != 0 && n <= GRID_MAX_DEF) begin
            compute_grid(n, steps);
            live_size  = n;
            grid_valid = 1;
            r.kind     = REPLY_DONE;
         end
      end else if (grid_valid && idx < live_size * live_size) begin
         r.kind  = REPLY_CELL;
         r.value = cur_grid[idx];
      end
      pending_replies.push_back(r);
   endtask

   // Sends one request in bursts with random gaps between them.
   task automatic send_request(input req_kind_type k, input int unsigned n,
                               input int unsigned steps, input int unsigned idx);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 10);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= k;
      req_tdata  <= {5'b0, idx[11:0], steps[15:0], n[6:0]};
      do @(posedge clock); while (!req_tready);
      predict_reply(k, n, steps, idx);
      burst_left--;
   endtask

   // Holds off new requests until every expected reply has come back.
   task automatic drain;
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [31:0] value);
      drain();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_APERTURE) rd_reg = value;
      else ld_reg = value;
   endtask

   task automatic read_all_cells(input int unsigned n);
      for (int c = 0; c < n * n; c++) send_request(REQ_READ, 0, 0, c);
   endtask

   task automatic test_read_before_start;
      send_request(REQ_READ, 0, 0, 0);
      send_request(REQ_READ, 0, 0, 4095);
   endtask

   task automatic test_bad_sizes;
      send_request(REQ_START, 0, 16'hFFFF, 0);
      send_request(REQ_START, 65, 1, 0);
      send_request(REQ_START, 127, 16'hFFFF, 4095);
   endtask

   task automatic test_small_grids;
      send_request(REQ_START, 1, 16'hFFFF, 0);
      send_request(REQ_READ, 0, 0, 0);
      send_request(REQ_READ, 0, 0, 1);
      send_request(REQ_START, 3, 2, 0);
      read_all_cells(3);
      // A rejected start must leave the previous grid intact.
      send_request(REQ_START, 100, 1, 0);
      send_request(REQ_READ, 0, 0, 8);
      send_request(REQ_READ, 0, 0, 9);
      send_request(REQ_START, 4, 0, 0);
      send_request(REQ_READ, 0, 0, 15);
   endtask

   // An ld of one, whose l20 is zero, makes the distance vanish at offset zero; then both registers at maximum.
   task automatic test_config_extremes;
      write_csr(CSR_DISTANCE, 32'd1);
      write_csr(CSR_APERTURE, 32'd0);
      send_request(REQ_START, 3, 2, 0);
      read_all_cells(3);
      write_csr(CSR_DISTANCE, 32'hFFFF_FFFF);
      write_csr(CSR_APERTURE, 32'hFFFF_FFFF);
      send_request(REQ_START, 3, 2, 0);
      read_all_cells(3);
      write_csr(CSR_APERTURE, RD_RESET);
      write_csr(CSR_DISTANCE, LD_RESET);
   endtask

   task automatic test_large_grid;
      send_request(REQ_START, 16, 1, 0);
      send_request(REQ_READ, 0, 0, 0);
      send_request(REQ_READ, 0, 0, 137);
      send_request(REQ_READ, 0, 0, 255);
      send_request(REQ_READ, 0, 0, 256);
   endtask

   // Mostly reads of valid cells, some starts on small grids, some noise.
   task automatic test_random_traffic(input int count);
      int unsigned pick, n, steps, idx;
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 5) begin
            n = $urandom_range(1, 4);
            if ($urandom_range(0, 9) == 0) n = $urandom_range(5, 6);
            steps = (n <= 2) ? ($urandom & 16'hFFFF) : $urandom_range(0, 3);
            send_request(REQ_START, n, steps, $urandom & 12'hFFF);
         end else if (pick < 9) begin
            n = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(65, 127);
            send_request(REQ_START, n, $urandom & 16'hFFFF, $urandom & 12'hFFF);
         end else if (pick < 14 || !grid_valid) begin
            send_request(REQ_READ, $urandom & 7'h7F, $urandom & 16'hFFFF,
                         $urandom & 12'hFFF);
         end else begin
            idx = $urandom_range(0, live_size * live_size - 1);
            send_request(REQ_READ, $urandom & 7'h7F, $urandom & 16'hFFFF, idx);
         end
      end
   endtask

   task automatic test_random_config;
      logic [31:0] ld;
      write_csr(CSR_APERTURE, $urandom);
      ld = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : $urandom;
      if (ld == 0) ld = 1;
      write_csr(CSR_DISTANCE, ld);
   endtask

   // Receiver stall pattern: ready, random, or mostly stalled, switched in phases.
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1;
      if (stall_phase % 300 == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= $urandom_range(0, 1);
         default: rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // Reply checking and the idle watchdog.
   always @(posedge clock) begin
      cell_reply_t exp_r;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_iterated_grid_propagation_unit: FAIL");
            $finish;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_replies.size() == 0) begin
               $error("unexpected reply: kind %0d value %h", rsp_tuser, rsp_tdata);
               error_count++;
            end else begin
               exp_r = pending_replies.pop_front();
               if (rsp_tuser !== exp_r.kind) begin
                  $error("reply_kind: expected %0d, actual %0d", exp_r.kind, rsp_tuser);
                  error_count++;
               end
               if (rsp_tdata !== exp_r.value) begin
                  $error("cell_value: expected %h, actual %h", exp_r.value, rsp_tdata);
                  error_count++;
               end
            end
         end
      end
   end

   initial begin
      clock       = 1'b0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      rsp_tready  = 1'b0;
      csr_we      = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      error_count = 0;
      burst_left  = 0;
      idle_cycles = 0;
      stall_phase = 0;
      stall_mode  = 0;
      live_size   = 0;
      live_sum    = 0;
      grid_valid  = 0;
      rd_reg      = RD_RESET;
      ld_reg      = LD_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_read_before_start();
      test_bad_sizes();
      test_small_grids();
      test_config_extremes();
      test_large_grid();
      test_random_traffic(300);
      test_random_config();
      test_random_traffic(300);
      test_random_config();
      test_random_traffic(300);

      drain();
      repeat (20) @(posedge clock);
      if (error_count == 0 && pending_replies.size() == 0) begin
         $display("tb_iterated_grid_propagation_unit: PASS");
      end else begin
         $display("tb_iterated_grid_propagation_unit: FAIL");
      end
      $finish;
   end

endmodule
